[rtl/pmpt_pkg.sv]
// Shared types and constants for the PS/2 mouse packet tracker.
// Used by the core and by its port checker; no dependencies.
package pmpt_pkg;

  // coordinate width default
  localparam int unsigned COORD_BITS_DEF = 12;

  // configuration port
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CFG_DATA_W-1:0] SCREEN_WIDTH_RST  = 13'd1024;
  localparam logic [CFG_DATA_W-1:0] SCREEN_HEIGHT_RST = 13'd768;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH  = 1'b0,
    CFG_SCREEN_HEIGHT = 1'b1
  } cfg_idx_e;

  // received byte
  localparam int unsigned RX_BYTE_W = 8;

  // header byte bit positions
  localparam int unsigned HDR_LEFT   = 0;
  localparam int unsigned HDR_RIGHT  = 1;
  localparam int unsigned HDR_MIDDLE = 2;
  localparam int unsigned HDR_SYNC   = 3;
  localparam int unsigned HDR_X_SIGN = 4;
  localparam int unsigned HDR_Y_SIGN = 5;
  localparam int unsigned HDR_X_OVF  = 6;
  localparam int unsigned HDR_Y_OVF  = 7;

  // motion magnitude: byte plus overflow extension
  localparam int unsigned MAG_W = 9;
  localparam logic [MAG_W-1:0] OVF_EXTRA = 9'd255;

  // position within a three-byte packet
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_XMOTION = 2'd1,
    PH_YMOTION = 2'd2
  } phase_e;

endpackage

[rtl/ps2_mouse_packet_tracker_core.sv]
// PS/2 mouse packet tracker core: byte stream in, cursor result per packet out.
// Depends on pmpt_pkg for constants, the packet phase enum and config indexes.
//
// Usage:
// - s_axis carries one received mouse byte per beat (tdata[7:0] = rx_byte).
// - m_axis carries one beat per completed three-byte packet with the clamped
//   cursor position, the three button bits and the cursor-visible flag.
// - cfg_* writes screen_width (index 0) or screen_height (index 1); it is
//   always ready and is meant to be written while no packet is in flight.
// Timing: a byte is taken into an input register; once it advances, the
//   packet logic updates the tracker state and, on the last byte of a packet,
//   loads the result register, which drives m_axis. One byte per cycle is
//   sustained unless a stall holds a last byte; decode, add and clamp are
//   combinational between the two registers.
// Reset: the first byte after reset is dropped, the cursor sits at 0,0, the
//   cursor is hidden and the screen is 1024 by 768.
// Stall: a held result stays on m_axis; the input register still takes one
//   more byte, and bytes that finish no packet keep flowing. Only a byte that
//   would complete a packet waits until the result register frees up.
module ps2_mouse_packet_tracker_core #(
  parameter int unsigned COORD_BITS = pmpt_pkg::COORD_BITS_DEF,
  localparam int unsigned OutFieldW = 2 * COORD_BITS + 4,
  localparam int unsigned OutDataW  = ((OutFieldW + 7) / 8) * 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input byte stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [pmpt_pkg::RX_BYTE_W-1:0]      s_axis_tdata,  // [7:0] rx_byte
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // low to high: pos_x, pos_y, left_down, middle_down, right_down,
  // cursor_shown, zero fill
  output logic [OutDataW-1:0]                 m_axis_tdata,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pmpt_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pmpt_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  // signed sum width: cursor plus or minus a 9-bit magnitude
  localparam int unsigned BaseW = (COORD_BITS > 9) ? COORD_BITS : 9;
  localparam int unsigned SumW  = BaseW + 2;
  // limit compare width
  localparam int unsigned LimW  = (COORD_BITS > pmpt_pkg::CFG_DATA_W) ?
                                  COORD_BITS : pmpt_pkg::CFG_DATA_W;
  localparam logic [LimW-1:0] CoordMax = LimW'((64'd1 << COORD_BITS) - 64'd1);

  // configuration registers
  logic [pmpt_pkg::CFG_DATA_W-1:0] width_q, height_q;
  // input register
  logic                            s1_valid_q, s1_valid_d;
  logic [pmpt_pkg::RX_BYTE_W-1:0]  byte_q;
  // tracker state
  pmpt_pkg::phase_e                phase_q, phase_d;
  logic                            skip_q, skip_d;
  logic [pmpt_pkg::RX_BYTE_W-1:0]  hdr_q, hdr_d;
  logic [pmpt_pkg::RX_BYTE_W-1:0]  xmot_q, xmot_d;
  logic [COORD_BITS-1:0]           cur_x_q, cur_x_d;
  logic [COORD_BITS-1:0]           cur_y_q, cur_y_d;
  logic                            shown_q, shown_d;
  // result register
  logic                            out_valid_q, out_valid_d;
  logic [OutDataW-1:0]             out_data_q, out_data_d;

  logic                            in_beat;
  logic                            produce;
  logic                            advance;
  logic [COORD_BITS-1:0]           lim_x, lim_y;
  logic [SumW-1:0]                 dx, dy;
  logic [SumW-1:0]                 nx, ny;
  logic [COORD_BITS-1:0]           new_x, new_y;
  logic                            new_shown;

  // signed motion from a byte, its sign bit and its overflow bit
  function automatic logic [SumW-1:0] motion(input logic [7:0] b, input logic neg,
                                             input logic ovf);
    logic [7:0]       m8;
    logic [pmpt_pkg::MAG_W-1:0] mag;
    m8  = neg ? (8'd0 - b) : b;
    mag = {1'b0, m8} + (ovf ? pmpt_pkg::OVF_EXTRA : '0);
    return neg ? (SumW'(0) - SumW'(mag)) : SumW'(mag);
  endfunction

  // screen size to largest coordinate, saturated to the coordinate range
  function automatic logic [COORD_BITS-1:0] limit_of(
      input logic [pmpt_pkg::CFG_DATA_W-1:0] size);
    logic [LimW-1:0] lim;
    lim = (size == '0) ? '0 : LimW'(size - 1'b1);
    if (lim > CoordMax) lim = CoordMax;
    return lim[COORD_BITS-1:0];
  endfunction

  // clamp a signed sum to 0..lim
  function automatic logic [COORD_BITS-1:0] clamp(input logic [SumW-1:0] v,
                                                  input logic [COORD_BITS-1:0] lim);
    logic [COORD_BITS-1:0] r;
    if (v[SumW-1])                  r = '0;
    else if (v > SumW'(lim))        r = lim;
    else                            r = v[COORD_BITS-1:0];
    return r;
  endfunction

  // handshake and flow control
  assign cfg_ready_o   = 1'b1;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign produce       = s1_valid_q && !skip_q && (phase_q == pmpt_pkg::PH_YMOTION);
  assign advance       = s1_valid_q && (!produce || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || advance;
  assign s1_valid_d    = in_beat || (s1_valid_q && !advance);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= pmpt_pkg::SCREEN_WIDTH_RST;
      height_q <= pmpt_pkg::SCREEN_HEIGHT_RST;
    end else if (cfg_valid_i) begin
      unique case (pmpt_pkg::cfg_idx_e'(cfg_index_i))
        pmpt_pkg::CFG_SCREEN_WIDTH:  width_q  <= cfg_data_i;
        pmpt_pkg::CFG_SCREEN_HEIGHT: height_q <= cfg_data_i;
      endcase
    end
  end

  // packet arithmetic on the last byte
  assign lim_x = limit_of(width_q);
  assign lim_y = limit_of(height_q);
  assign dx    = motion(xmot_q, hdr_q[pmpt_pkg::HDR_X_SIGN], hdr_q[pmpt_pkg::HDR_X_OVF]);
  assign dy    = motion(byte_q, hdr_q[pmpt_pkg::HDR_Y_SIGN], hdr_q[pmpt_pkg::HDR_Y_OVF]);
  assign nx    = SumW'(cur_x_q) + dx;
  assign ny    = SumW'(cur_y_q) - dy;
  assign new_x = clamp(nx, lim_x);
  assign new_y = clamp(ny, lim_y);

  // right button wins over left
  always_comb begin
    new_shown = shown_q;
    if (hdr_q[pmpt_pkg::HDR_LEFT])  new_shown = 1'b1;
    if (hdr_q[pmpt_pkg::HDR_RIGHT]) new_shown = 1'b0;
  end

  // next phase and packet capture
  always_comb begin
    phase_d = phase_q;
    skip_d  = skip_q;
    hdr_d   = hdr_q;
    xmot_d  = xmot_q;
    if (advance) begin
      if (skip_q) begin
        skip_d = 1'b0;
      end else begin
        unique case (phase_q)
          pmpt_pkg::PH_XMOTION: begin
            xmot_d  = byte_q;
            phase_d = pmpt_pkg::PH_YMOTION;
          end
          pmpt_pkg::PH_YMOTION: begin
            phase_d = pmpt_pkg::PH_HEADER;
          end
          default: begin
            if (byte_q[pmpt_pkg::HDR_SYNC]) begin
              hdr_d   = byte_q;
              phase_d = pmpt_pkg::PH_XMOTION;
            end else begin
              phase_d = pmpt_pkg::PH_HEADER;
            end
          end
        endcase
      end
    end
  end

  // cursor, flags and result register loads
  always_comb begin
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    shown_d     = shown_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    if (advance && produce) begin
      cur_x_d     = new_x;
      cur_y_d     = new_y;
      shown_d     = new_shown;
      out_valid_d = 1'b1;
      out_data_d  = OutDataW'({new_shown,
                               hdr_q[pmpt_pkg::HDR_RIGHT],
                               hdr_q[pmpt_pkg::HDR_MIDDLE],
                               hdr_q[pmpt_pkg::HDR_LEFT],
                               new_y, new_x});
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      phase_q     <= pmpt_pkg::PH_HEADER;
      skip_q      <= 1'b1;
      hdr_q       <= '0;
      xmot_q      <= '0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      shown_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      phase_q     <= phase_d;
      skip_q      <= skip_d;
      hdr_q       <= hdr_d;
      xmot_q      <= xmot_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      shown_q     <= shown_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      byte_q <= s_axis_tdata;
    end
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

[rtl/pmpt_checker.sv]
// Port-level checks for the PS/2 mouse packet tracker core, bound to the top.
// Depends on pmpt_pkg for config reset values and register indexes.
module pmpt_checker #(
  parameter int unsigned COORD_BITS = pmpt_pkg::COORD_BITS_DEF,
  localparam int unsigned OutFieldW = 2 * COORD_BITS + 4,
  localparam int unsigned OutDataW  = ((OutFieldW + 7) / 8) * 8
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  // low to high: pos_x, pos_y, buttons, cursor_shown, zero fill
  input logic [OutDataW-1:0]             m_axis_tdata,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o,
  input logic [pmpt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input logic [pmpt_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic [2:0]                      in_cnt_q;
  logic [pmpt_pkg::CFG_DATA_W-1:0] width_q, height_q;
  logic [COORD_BITS-1:0]           pos_x, pos_y;
  logic                            in_beat;

  assign in_beat = s_axis_tvalid && s_axis_tready;
  assign pos_x   = m_axis_tdata[COORD_BITS-1:0];
  assign pos_y   = m_axis_tdata[2*COORD_BITS-1:COORD_BITS];

  // count input beats, saturating at four
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q <= '0;
    end else if (in_beat && (in_cnt_q != 3'd4)) begin
      in_cnt_q <= in_cnt_q + 3'd1;
    end
  end

  // shadow of the screen size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= pmpt_pkg::SCREEN_WIDTH_RST;
      height_q <= pmpt_pkg::SCREEN_HEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (pmpt_pkg::cfg_idx_e'(cfg_index_i))
        pmpt_pkg::CFG_SCREEN_WIDTH:  width_q  <= cfg_data_i;
        pmpt_pkg::CFG_SCREEN_HEIGHT: height_q <= cfg_data_i;
      endcase
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // no result before a dropped byte and a full packet
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> in_cnt_q == 3'd4)
    else $error("result before four input beats");

  // zero fill above the fields
  a_zero_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata >> OutFieldW) == '0)
    else $error("fill bits of result are not zero");

  // cursor stays within the screen
  a_x_in_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (width_q != '0) |->
      (pmpt_pkg::CFG_DATA_W + COORD_BITS)'(pos_x) <
      (pmpt_pkg::CFG_DATA_W + COORD_BITS)'(width_q))
    else $error("pos_x beyond screen width");

  a_y_in_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (height_q != '0) |->
      (pmpt_pkg::CFG_DATA_W + COORD_BITS)'(pos_y) <
      (pmpt_pkg::CFG_DATA_W + COORD_BITS)'(height_q))
    else $error("pos_y beyond screen height");

endmodule

bind ps2_mouse_packet_tracker_core pmpt_checker #(
  .COORD_BITS (COORD_BITS)
) u_pmpt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_o   (cfg_ready_o),
  .cfg_index_i   (cfg_index_i),
  .cfg_data_i    (cfg_data_i)
);
